/* design/shm_pkg.sv */
package shm_pkg;

    localparam int ID_W        = 8;
    localparam int TIME_W      = 32;
    localparam int SW_CNT_W    = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRIMARY_ID     = 3'd0,
        REG_FALLBACK_ID    = 3'd1,
        REG_STALE_TICKS    = 3'd2,
        REG_FB_WARN_TICKS  = 3'd3,
        REG_FB_ERROR_TICKS = 3'd4,
        REG_SW_WARN_COUNT  = 3'd5,
        REG_SW_ERROR_COUNT = 3'd6,
        REG_WINDOW_TICKS   = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        LVL_OK    = 2'd0,
        LVL_WARN  = 2'd1,
        LVL_ERROR = 2'd2,
        LVL_STALE = 2'd3
    } level_t;

    typedef enum logic [3:0] {
        RSN_NONE      = 4'd0,
        RSN_TIMEOUT   = 4'd1,
        RSN_PRIMARY   = 4'd2,
        RSN_FALLBACK  = 4'd3,
        RSN_UNKNOWN   = 4'd4,
        RSN_FB_LONG   = 4'd5,
        RSN_FB_WARN   = 4'd6,
        RSN_EXCESSIVE = 4'd7,
        RSN_UNSTABLE  = 4'd8
    } reason_t;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_REPORT = 1'b1
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [ID_W-1:0]   id;
    } op_t;

    typedef struct packed {
        logic [ID_W-1:0]     primary_id;
        logic [ID_W-1:0]     fallback_id;
        logic [TIME_W-1:0]   stale_ticks;
        logic [TIME_W-1:0]   fb_warn_ticks;
        logic [TIME_W-1:0]   fb_error_ticks;
        logic [SW_CNT_W-1:0] sw_warn_count;
        logic [SW_CNT_W-1:0] sw_error_count;
        logic [TIME_W-1:0]   window_ticks;
    } cfg_t;

    localparam logic [ID_W-1:0]     RST_PRIMARY_ID     = 8'd0;
    localparam logic [ID_W-1:0]     RST_FALLBACK_ID    = 8'd1;
    localparam logic [TIME_W-1:0]   RST_STALE_TICKS    = 32'd3000;
    localparam logic [TIME_W-1:0]   RST_FB_WARN_TICKS  = 32'd10000;
    localparam logic [TIME_W-1:0]   RST_FB_ERROR_TICKS = 32'd60000;
    localparam logic [SW_CNT_W-1:0] RST_SW_WARN_COUNT  = 5'd3;
    localparam logic [SW_CNT_W-1:0] RST_SW_ERROR_COUNT = 5'd10;
    localparam logic [TIME_W-1:0]   RST_WINDOW_TICKS   = 32'd60000;

endpackage

/* design/shm_in_if.sv */
interface shm_in_if;

    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [shm_pkg::ID_W-1:0]    source_id;

    modport source (output valid, output cmd, output source_id, input ready);
    modport sink   (input valid, input cmd, input source_id, output ready);

endinterface

/* design/shm_out_if.sv */
interface shm_out_if #(
    parameter int CNT_W = 5
);

    logic                        valid;
    logic                        ready;
    logic [1:0]                  level;
    logic [3:0]                  reason;
    logic [CNT_W-1:0]            ring_count;
    logic [shm_pkg::TIME_W-1:0]  fallback_ticks;
    logic [shm_pkg::TIME_W-1:0]  idle_ticks;
    logic [shm_pkg::ID_W-1:0]    active_source;

    modport source (
        output valid, output level, output reason, output ring_count,
        output fallback_ticks, output idle_ticks, output active_source,
        input ready
    );
    modport sink (
        input valid, input level, input reason, input ring_count,
        input fallback_ticks, input idle_ticks, input active_source,
        output ready
    );

endinterface

/* design/shm_ram.sv */
module shm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/shm_front.sv */
module shm_front (
    input  logic            clk,
    input  logic            rst_n,
    shm_in_if.sink          item,
    output logic            op_valid,
    output shm_pkg::op_t    op,
    input  logic            op_pop
);

    localparam int PTR_W = (shm_pkg::QUEUE_DEPTH > 1) ? $clog2(shm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(shm_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(shm_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(shm_pkg::QUEUE_DEPTH);

    shm_pkg::op_t     q_reg [shm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    shm_pkg::op_t     op_in;
    logic             push;
    logic             pop;

    // classify: a tick carries no id
    always_comb
    begin
        op_in.kind = item.cmd ? shm_pkg::OP_REPORT : shm_pkg::OP_TICK;
        op_in.id   = item.cmd ? item.source_id : '0;
    end

    assign item.ready = (count_reg != CNT_FULL);
    assign push       = item.valid && item.ready;
    assign op_valid   = (count_reg != '0);
    assign pop        = op_pop && op_valid;
    assign op         = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= op_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* design/shm_back.sv */
module shm_back #(
    parameter int SWITCH_DEPTH = 16,
    localparam int IDX_W = (SWITCH_DEPTH > 1) ? $clog2(SWITCH_DEPTH) : 1,
    localparam int CNT_W = $clog2(SWITCH_DEPTH + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  shm_pkg::cfg_t   cfg,
    input  logic            op_valid,
    input  shm_pkg::op_t    op,
    output logic            op_pop,
    shm_out_if.source       status
);

    localparam int TW    = shm_pkg::TIME_W;
    localparam int CMP_W = (CNT_W > shm_pkg::SW_CNT_W) ? CNT_W : shm_pkg::SW_CNT_W;
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(SWITCH_DEPTH - 1);
    localparam logic [CNT_W-1:0] FILL_FULL  = CNT_W'(SWITCH_DEPTH);
    localparam logic [CNT_W:0]   DEPTH_WIDE = (CNT_W + 1)'(SWITCH_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_DIFF,
        S_OUT
    } state_t;

    state_t                       state_reg;
    logic [TW-1:0]                tick_reg;
    logic [TW-1:0]                last_reg;
    logic [TW-1:0]                fb_start_reg;
    logic                         seen_reg;
    logic                         in_fb_reg;
    logic [shm_pkg::ID_W-1:0]     cur_reg;
    logic [IDX_W-1:0]             head_reg;
    logic [CNT_W-1:0]             fill_reg;
    logic [TW-1:0]                idle_reg;
    logic [TW-1:0]                fb_reg;

    logic                         out_valid_reg;
    logic [1:0]                   out_level_reg;
    logic [3:0]                   out_reason_reg;
    logic [CNT_W-1:0]             out_count_reg;
    logic [TW-1:0]                out_fb_reg;
    logic [TW-1:0]                out_idle_reg;
    logic [shm_pkg::ID_W-1:0]     out_src_reg;

    logic                         is_switch;
    logic                         ring_we;
    logic [IDX_W-1:0]             ring_waddr;
    logic [CNT_W:0]               tail_sum;
    logic [IDX_W-1:0]             head_inc;
    logic [TW-1:0]                ring_rdata;
    logic                         aged;
    shm_pkg::level_t              lvl;
    shm_pkg::reason_t             rsn;
    logic [CMP_W-1:0]             fill_cmp;
    logic [CMP_W-1:0]             sw_warn_cmp;
    logic [CMP_W-1:0]             sw_err_cmp;
    logic                         out_free;

    assign op_pop    = (state_reg == S_IDLE) && op_valid;
    assign is_switch = (op.kind == shm_pkg::OP_REPORT) && seen_reg && (op.id != cur_reg);
    assign ring_we   = op_pop && is_switch;

    // tail slot = (head + fill) mod depth, the sum stays below twice the depth
    assign tail_sum   = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(fill_reg);
    assign head_inc   = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
    always_comb
    begin
        if (fill_reg != FILL_FULL)
        begin
            ring_waddr = (tail_sum >= DEPTH_WIDE) ? IDX_W'(tail_sum - DEPTH_WIDE)
                                                  : IDX_W'(tail_sum);
        end
        else
        begin
            ring_waddr = head_reg;
        end
    end

    shm_ram #(
        .WIDTH (TW),
        .DEPTH (SWITCH_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (tick_reg),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    assign aged = (fill_reg != '0) && ((tick_reg - ring_rdata) > cfg.window_ticks);

    assign fill_cmp    = CMP_W'(fill_reg);
    assign sw_warn_cmp = CMP_W'(cfg.sw_warn_count);
    assign sw_err_cmp  = CMP_W'(cfg.sw_error_count);

    always_comb
    begin
        if (!seen_reg)
        begin
            lvl = shm_pkg::LVL_STALE;
            rsn = shm_pkg::RSN_NONE;
        end
        else if (idle_reg > cfg.stale_ticks)
        begin
            lvl = shm_pkg::LVL_STALE;
            rsn = shm_pkg::RSN_TIMEOUT;
        end
        else
        begin
            if (cur_reg == cfg.primary_id)
            begin
                lvl = shm_pkg::LVL_OK;
                rsn = shm_pkg::RSN_PRIMARY;
            end
            else if (cur_reg == cfg.fallback_id)
            begin
                lvl = shm_pkg::LVL_WARN;
                rsn = shm_pkg::RSN_FALLBACK;
            end
            else
            begin
                lvl = shm_pkg::LVL_ERROR;
                rsn = shm_pkg::RSN_UNKNOWN;
            end
            if (in_fb_reg)
            begin
                if (fb_reg > cfg.fb_error_ticks && lvl < shm_pkg::LVL_ERROR)
                begin
                    lvl = shm_pkg::LVL_ERROR;
                    rsn = shm_pkg::RSN_FB_LONG;
                end
                else if (fb_reg > cfg.fb_warn_ticks && lvl < shm_pkg::LVL_WARN)
                begin
                    lvl = shm_pkg::LVL_WARN;
                    rsn = shm_pkg::RSN_FB_WARN;
                end
            end
            if (fill_cmp > sw_err_cmp && lvl < shm_pkg::LVL_ERROR)
            begin
                lvl = shm_pkg::LVL_ERROR;
                rsn = shm_pkg::RSN_EXCESSIVE;
            end
            else if (fill_cmp > sw_warn_cmp && lvl < shm_pkg::LVL_WARN)
            begin
                lvl = shm_pkg::LVL_WARN;
                rsn = shm_pkg::RSN_UNSTABLE;
            end
        end
    end

    assign out_free = !out_valid_reg || status.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_reg       <= '0;
            last_reg       <= '0;
            fb_start_reg   <= '0;
            seen_reg       <= 1'b0;
            in_fb_reg      <= 1'b0;
            cur_reg        <= '0;
            head_reg       <= '0;
            fill_reg       <= '0;
            idle_reg       <= '0;
            fb_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_level_reg  <= '0;
            out_reason_reg <= '0;
            out_count_reg  <= '0;
            out_fb_reg     <= '0;
            out_idle_reg   <= '0;
            out_src_reg    <= '0;
        end
        else
        begin
            // clear on transfer unless the next result loads in this cycle
            if (status.valid && status.ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (op_valid)
                    begin
                        if (op.kind == shm_pkg::OP_TICK)
                        begin
                            tick_reg  <= tick_reg + 1'b1;
                            state_reg <= S_DIFF;
                        end
                        else
                        begin
                            if (is_switch)
                            begin
                                if (fill_reg != FILL_FULL)
                                begin
                                    fill_reg <= fill_reg + 1'b1;
                                end
                                else
                                begin
                                    head_reg <= head_inc;
                                end
                                state_reg <= S_RD;
                            end
                            else
                            begin
                                state_reg <= S_DIFF;
                            end
                            if (op.id == cfg.fallback_id &&
                                (cur_reg != cfg.fallback_id || !seen_reg))
                            begin
                                fb_start_reg <= tick_reg;
                                in_fb_reg    <= 1'b1;
                            end
                            else if (op.id == cfg.primary_id)
                            begin
                                in_fb_reg <= 1'b0;
                            end
                            cur_reg  <= op.id;
                            last_reg <= tick_reg;
                            seen_reg <= 1'b1;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (aged)
                    begin
                        head_reg  <= head_inc;
                        fill_reg  <= fill_reg - 1'b1;
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    idle_reg  <= tick_reg - last_reg;
                    fb_reg    <= in_fb_reg ? (tick_reg - fb_start_reg) : '0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_level_reg  <= lvl;
                        out_reason_reg <= rsn;
                        out_count_reg  <= fill_reg;
                        out_fb_reg     <= seen_reg ? fb_reg : '0;
                        out_idle_reg   <= seen_reg ? idle_reg : '0;
                        out_src_reg    <= seen_reg ? cur_reg : '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign status.valid          = out_valid_reg;
    assign status.level          = out_level_reg;
    assign status.reason         = out_reason_reg;
    assign status.ring_count     = out_count_reg;
    assign status.fallback_ticks = out_fb_reg;
    assign status.idle_ticks     = out_idle_reg;
    assign status.active_source  = out_src_reg;

endmodule

/* design/source_health_monitor_core.sv */
// Channel   Dir   Payload                                              Transfer
// --------  ----  ---------------------------------------------------  ------------------
// item      in    cmd (tick/report), source_id[7:0]                    valid & ready
// status    out   level, reason, ring_count, fallback_ticks,           valid & ready
//                 idle_ticks, active_source
// cfg       in    cfg_we, cfg_index[2:0], cfg_wdata[31:0]              cfg_we
//
// A tick or a report that is not a source switch passes the back end's update,
//   difference and result states. A switch adds a ring read and compare, repeated
//   for each aged entry dropped from the switch ring; the single-read-port ring
//   RAM with its registered read sets that per-entry cost.
// A 2-entry queue sits between front and back, so item stays ready while the
//   back end works; it drops ready only when the queue is full.
// The status register holds a result until it is taken; the back end stalls
//   only when it has its next result ready and that register is still full.
// Reset: all control state clears at once; the ring needs no clearing pass
//   because only entries counted by the fill level are ever read.
module source_health_monitor_core #(
    parameter int SWITCH_DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    shm_in_if.sink                             item,
    shm_out_if.source                          status,
    input  logic                               cfg_we,
    input  logic [shm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [shm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    shm_pkg::cfg_t   cfg_reg;
    logic            op_valid;
    shm_pkg::op_t    op;
    logic            op_pop;

    // Configuration registers: take the low bits of the write data, hold otherwise.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.primary_id     <= shm_pkg::RST_PRIMARY_ID;
            cfg_reg.fallback_id    <= shm_pkg::RST_FALLBACK_ID;
            cfg_reg.stale_ticks    <= shm_pkg::RST_STALE_TICKS;
            cfg_reg.fb_warn_ticks  <= shm_pkg::RST_FB_WARN_TICKS;
            cfg_reg.fb_error_ticks <= shm_pkg::RST_FB_ERROR_TICKS;
            cfg_reg.sw_warn_count  <= shm_pkg::RST_SW_WARN_COUNT;
            cfg_reg.sw_error_count <= shm_pkg::RST_SW_ERROR_COUNT;
            cfg_reg.window_ticks   <= shm_pkg::RST_WINDOW_TICKS;
        end
        else if (cfg_we)
        begin
            case (shm_pkg::cfg_reg_t'(cfg_index))
                shm_pkg::REG_PRIMARY_ID:
                    cfg_reg.primary_id <= cfg_wdata[shm_pkg::ID_W-1:0];
                shm_pkg::REG_FALLBACK_ID:
                    cfg_reg.fallback_id <= cfg_wdata[shm_pkg::ID_W-1:0];
                shm_pkg::REG_STALE_TICKS:
                    cfg_reg.stale_ticks <= cfg_wdata[shm_pkg::TIME_W-1:0];
                shm_pkg::REG_FB_WARN_TICKS:
                    cfg_reg.fb_warn_ticks <= cfg_wdata[shm_pkg::TIME_W-1:0];
                shm_pkg::REG_FB_ERROR_TICKS:
                    cfg_reg.fb_error_ticks <= cfg_wdata[shm_pkg::TIME_W-1:0];
                shm_pkg::REG_SW_WARN_COUNT:
                    cfg_reg.sw_warn_count <= cfg_wdata[shm_pkg::SW_CNT_W-1:0];
                shm_pkg::REG_SW_ERROR_COUNT:
                    cfg_reg.sw_error_count <= cfg_wdata[shm_pkg::SW_CNT_W-1:0];
                shm_pkg::REG_WINDOW_TICKS:
                    cfg_reg.window_ticks <= cfg_wdata[shm_pkg::TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front end: accept and classify each transfer, queue it for the back end.
    shm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop)
    );

    // Back end: advance time, track source and fallback, prune the switch ring,
    // grade the status and hold it in the output register.
    shm_back #(
        .SWITCH_DEPTH (SWITCH_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop),
        .status   (status)
    );

endmodule

/* design/shm_checker.sv */
module shm_checker #(
    parameter int SWITCH_DEPTH = 16,
    localparam int CNT_W = $clog2(SWITCH_DEPTH + 1)
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         valid,
    input logic                         ready,
    input logic [1:0]                   level,
    input logic [3:0]                   reason,
    input logic [CNT_W-1:0]             ring_count,
    input logic [shm_pkg::TIME_W-1:0]   fallback_ticks,
    input logic [shm_pkg::TIME_W-1:0]   idle_ticks,
    input logic [shm_pkg::ID_W-1:0]     active_source
);

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(SWITCH_DEPTH);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
    else $error("status dropped while stalled");

    // before any report every history field reads zero
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && reason == shm_pkg::RSN_NONE |->
            level == shm_pkg::LVL_STALE && idle_ticks == '0 &&
            fallback_ticks == '0 && active_source == '0 && ring_count == '0)
    else $error("no-report status carries history");

    // fallback escalation only with a nonzero fallback duration
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && (reason == shm_pkg::RSN_FB_LONG || reason == shm_pkg::RSN_FB_WARN) |->
            fallback_ticks != '0)
    else $error("fallback escalation without fallback time");

    // the ring count never passes the ring depth, and OK comes only from primary
    assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> ring_count <= COUNT_MAX &&
            (level != shm_pkg::LVL_OK || reason == shm_pkg::RSN_PRIMARY))
    else $error("switch count or OK status out of range");

endmodule

bind source_health_monitor_core shm_checker #(
    .SWITCH_DEPTH (SWITCH_DEPTH)
) u_shm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (status.valid),
    .ready          (status.ready),
    .level          (status.level),
    .reason         (status.reason),
    .ring_count     (status.ring_count),
    .fallback_ticks (status.fallback_ticks),
    .idle_ticks     (status.idle_ticks),
    .active_source  (status.active_source)
);
